/* hw/rtl/jss_pkg.sv */
// shared types, codes and constants of the joystick servo steering shaper
package jss_pkg;

    localparam int ANG_W    = 15;   // angles in hundredths of a degree
    localparam int AXIS_W   = 16;   // q1.15 axis samples
    localparam int CFG_W    = 16;   // configuration write data
    localparam int CFG_IDX_W = 3;
    localparam int MS_W     = 16;
    localparam int DUTY_W   = 22;
    localparam int OPD_W    = 16;   // multiplier and divisor operand width
    localparam int PROD_W   = 2 * OPD_W;
    localparam int TGT_W    = PROD_W + 1;
    localparam int NUM_W    = PROD_W + 2;

    localparam int PULSE_MIN_US = 500;
    localparam int PULSE_MAX_US = 2500;
    localparam int ANGLE_FULL   = 18000;
    localparam int PULSE_SPAN   = PULSE_MAX_US - PULSE_MIN_US;
    localparam int DUTY_BASE    = PULSE_MIN_US * ANGLE_FULL;
    localparam int DUTY_DIV     = ANGLE_FULL / 1000;

    localparam logic [OPD_W-1:0] PULSE_SPAN_MAG =
        OPD_W'((PULSE_SPAN < 0) ? -PULSE_SPAN : PULSE_SPAN);
    localparam logic PULSE_SPAN_NEG = (PULSE_SPAN < 0);
    localparam logic signed [NUM_W-1:0] DUTY_BASE_S = NUM_W'(DUTY_BASE);
    localparam logic [OPD_W-1:0] DUTY_DIVISOR = OPD_W'(DUTY_DIV);
    localparam logic [DUTY_W-1:0] DUTY_MAX = '1;
    localparam logic [AXIS_W:0] Q15_ONE = (AXIS_W+1)'(32768);

    localparam logic [ANG_W-1:0] RST_ANGLE_MIN    = 15'd1000;
    localparam logic [ANG_W-1:0] RST_ANGLE_MAX    = 15'd16200;
    localparam logic [ANG_W-1:0] RST_ANGLE_CENTER = 15'd9000;
    localparam logic [ANG_W-1:0] RST_TWIST_THR    = 15'd26214;
    localparam logic [ANG_W-1:0] RST_STICK_DZ     = 15'd3277;
    localparam logic [ANG_W-1:0] RST_DEADBAND     = 15'd200;
    localparam logic [ANG_W-1:0] RST_SLEW_STEP    = 15'd500;
    localparam logic [MS_W-1:0]  RST_UPD_INTERVAL = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_MIN,
        CFG_ANGLE_MAX,
        CFG_ANGLE_CENTER,
        CFG_TWIST_THR,
        CFG_STICK_DZ,
        CFG_DEADBAND,
        CFG_SLEW_STEP,
        CFG_UPD_INTERVAL
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SRC_CENTER,
        SRC_RIGHT,
        SRC_LEFT,
        SRC_PROP
    } t_src;

    typedef enum logic [2:0] {
        K_NONE,
        K_TICK,
        K_CENTER,
        K_SNAP_R,
        K_SNAP_L,
        K_PROP
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_OFF,
        S_DIVLD_OFF,
        S_DIV_OFF,
        S_TGT,
        S_DIFF,
        S_SLEW,
        S_CLAMP,
        S_MUL_DUTY,
        S_DIVLD_DUTY,
        S_DIV_DUTY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul_off;
        logic divld_off;
        logic tgt;
        logic diff;
        logic slew;
        logic clamp;
        logic mul_duty;
        logic divld_duty;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  div_busy;
        logic  skip;
        logic  out_free;
    } t_dp_stat;

endpackage

/* hw/rtl/joystick_servo_steering_shaper_core.sv */
// Joystick servo steering shaper. Millisecond ticks give no result. A center press or
// twist snap gives its angle and duty after the beat is taken; a proportional stick
// sample passes twice through the shared 2-bit-per-cycle divider (once for the
// deadzone rescale, once for the angle-to-duty conversion). A sample that is
// skipped (update interval not reached, inside the deadband, or nothing to do)
// gives no result. One sample is worked on at a time; a finished result sits in
// the output register, so the next beat is taken while it waits. Configuration
// writes are always ready and are meant for while the block is idle.
module joystick_servo_steering_shaper_core import jss_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_func,
    input  logic                     i_center_present,
    input  logic                     i_center_pressed,
    input  logic                     i_twist_present,
    input  logic signed [AXIS_W-1:0] i_twist_value,
    input  logic                     i_stick_present,
    input  logic signed [AXIS_W-1:0] i_stick_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [ANG_W-1:0]         o_angle,
    output logic [DUTY_W-1:0]        o_duty_ns,
    output logic [1:0]               o_source,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    jss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    jss_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_wr         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_center_present (i_center_present),
        .i_center_pressed (i_center_pressed),
        .i_twist_present  (i_twist_present),
        .i_twist_value    (i_twist_value),
        .i_stick_present  (i_stick_present),
        .i_stick_value    (i_stick_value),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_angle          (o_angle),
        .o_duty_ns        (o_duty_ns),
        .o_source         (o_source)
    );

    // the divider is never left running once the sequencer is back to taking beats
    a_div_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_stat.div_busy)
        else $error("divider busy while input is open");

    // a result is only written when the output register can take it
    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_stat.out_free)
        else $error("result written over a pending beat");

    // a new output beat always comes from a write of the result register
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.emit))
        else $error("output valid without a result write");

    // accepting an input beat only happens with the input open
    a_accept_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |-> !o_in_stall && !w_cmd.emit)
        else $error("input taken while a sample is in flight");

endmodule

/* hw/rtl/jss_div.sv */
// radix-4 restoring divider, two quotient bits per cycle
module jss_div import jss_pkg::*; #(
    parameter int DIVIDEND_W = PROD_W,
    parameter int DIVISOR_W  = OPD_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [DIVIDEND_W-1:0] o_quot
);

    localparam int STEPS = DIVIDEND_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvsr;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;

    logic [DIVISOR_W:0]    rem1, rem1s, rem2, rem2s;
    logic                  ge1, ge2;

    always_comb begin
        rem1  = {r_rem, r_quo[DIVIDEND_W-1]};
        ge1   = (rem1 >= {1'b0, r_dvsr});
        rem1s = ge1 ? (rem1 - {1'b0, r_dvsr}) : rem1;
        rem2  = {rem1s[DIVISOR_W-1:0], r_quo[DIVIDEND_W-2]};
        ge2   = (rem2 >= {1'b0, r_dvsr});
        rem2s = ge2 ? (rem2 - {1'b0, r_dvsr}) : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-3:0], ge1, ge2};
            r_rem <= rem2s[DIVISOR_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

/* hw/rtl/jss_dp.sv */
// datapath: configuration, steering state, shared multiplier and divider, result register
module jss_dp import jss_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic                      i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_func,
    input  logic                      i_center_present,
    input  logic                      i_center_pressed,
    input  logic                      i_twist_present,
    input  logic signed [AXIS_W-1:0]  i_twist_value,
    input  logic                      i_stick_present,
    input  logic signed [AXIS_W-1:0]  i_stick_value,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic [ANG_W-1:0]          o_angle,
    output logic [DUTY_W-1:0]         o_duty_ns,
    output logic [1:0]                o_source
);

    // configuration
    logic [ANG_W-1:0] r_angle_min, r_angle_max, r_angle_center, r_twist_thr;
    logic [ANG_W-1:0] r_stick_dz, r_deadband, r_slew_step;
    logic [MS_W-1:0]  r_upd_interval;

    // steering state
    logic [ANG_W-1:0] r_cur;
    logic             r_lat_l, r_lat_r;
    logic [MS_W-1:0]  r_ms;

    // work registers
    logic [OPD_W-1:0]        r_mdz, r_span_mag;
    logic                    r_qneg;
    logic [PROD_W-1:0]       r_prod;
    logic signed [TGT_W-1:0] r_target, r_diff;
    logic [ANG_W-1:0]        r_angle;
    t_src                    r_source;

    logic                    r_out_valid;
    logic [ANG_W-1:0]        r_out_angle;
    logic [DUTY_W-1:0]       r_out_duty;
    t_src                    r_out_source;

    // accept-time decode
    logic signed [AXIS_W:0]  tw_ext, thr_pos, thr_neg, st_ext, st_abs;
    logic                    tw_hi, tw_lo, st_neg, ms_ok;
    logic [OPD_W-1:0]        mag, mdz, span_mag;
    logic signed [OPD_W-1:0] span;
    t_kind                   kind;

    logic [OPD_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       div_dividend, div_quot;
    logic [OPD_W-1:0]        div_divisor;
    logic                    div_busy;

    logic signed [TGT_W-1:0] cur_ext, ctr_ext, quo_ext, slew_ext, adiff;
    logic signed [NUM_W-1:0] duty_num;
    logic                    skip, big;
    logic [ANG_W-1:0]        clamped;
    logic [DUTY_W-1:0]       duty_sat;

    always_comb begin
        tw_ext  = {i_twist_value[AXIS_W-1], i_twist_value};
        thr_pos = {2'b00, r_twist_thr};
        thr_neg = -thr_pos;
        tw_hi   = (tw_ext > thr_pos);
        tw_lo   = (tw_ext < thr_neg);
        ms_ok   = (r_ms >= r_upd_interval);

        if (!i_func) begin
            kind = K_TICK;
        end else if (i_center_present && i_center_pressed) begin
            kind = K_CENTER;
        end else if (i_twist_present && tw_hi && !r_lat_r) begin
            kind = K_SNAP_R;
        end else if (i_twist_present && tw_lo && !r_lat_l) begin
            kind = K_SNAP_L;
        end else if (i_stick_present && ms_ok) begin
            kind = K_PROP;
        end else begin
            kind = K_NONE;
        end

        st_ext = {i_stick_value[AXIS_W-1], i_stick_value};
        st_neg = i_stick_value[AXIS_W-1];
        st_abs = st_neg ? -st_ext : st_ext;
        mag    = st_abs[OPD_W-1:0];
        mdz    = (mag >= {1'b0, r_stick_dz}) ? (mag - {1'b0, r_stick_dz}) : '0;
        span   = st_neg ? ({1'b0, r_angle_center} - {1'b0, r_angle_min})
                        : ({1'b0, r_angle_max} - {1'b0, r_angle_center});
        span_mag = span[OPD_W-1] ? OPD_W'(-span) : OPD_W'(span);
    end

    // shared multiplier and divider operand selection
    always_comb begin
        mul_a = i_cmd.mul_duty ? {{(OPD_W-ANG_W){1'b0}}, r_angle} : r_mdz;
        mul_b = i_cmd.mul_duty ? PULSE_SPAN_MAG : r_span_mag;

        duty_num = DUTY_BASE_S + (PULSE_SPAN_NEG ? -$signed({2'b00, r_prod})
                                                 :  $signed({2'b00, r_prod}));
        if (i_cmd.divld_duty) begin
            div_dividend = duty_num[NUM_W-1] ? '0 : duty_num[PROD_W-1:0];
            div_divisor  = DUTY_DIVISOR;
        end else begin
            div_dividend = r_prod;
            div_divisor  = OPD_W'(Q15_ONE - {2'b00, r_stick_dz});
        end
    end

    jss_div #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (OPD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.divld_off | i_cmd.divld_duty),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    always_comb begin
        cur_ext  = TGT_W'({1'b0, r_cur});
        ctr_ext  = TGT_W'({1'b0, r_angle_center});
        quo_ext  = $signed({1'b0, div_quot});
        slew_ext = TGT_W'({1'b0, r_slew_step});
        adiff    = r_diff[TGT_W-1] ? -r_diff : r_diff;
        skip     = (adiff < TGT_W'({1'b0, r_deadband}));
        big      = (adiff > slew_ext);

        if (r_target < TGT_W'({1'b0, r_angle_min})) begin
            clamped = r_angle_min;
        end else if (r_target > TGT_W'({1'b0, r_angle_max})) begin
            clamped = r_angle_max;
        end else begin
            clamped = r_target[ANG_W-1:0];
        end

        duty_sat = (div_quot > PROD_W'(DUTY_MAX)) ? DUTY_MAX : div_quot[DUTY_W-1:0];
    end

    // configuration and steering state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_min    <= RST_ANGLE_MIN;
            r_angle_max    <= RST_ANGLE_MAX;
            r_angle_center <= RST_ANGLE_CENTER;
            r_twist_thr    <= RST_TWIST_THR;
            r_stick_dz     <= RST_STICK_DZ;
            r_deadband     <= RST_DEADBAND;
            r_slew_step    <= RST_SLEW_STEP;
            r_upd_interval <= RST_UPD_INTERVAL;
        end else if (i_cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ANGLE_MIN:    r_angle_min    <= i_cfg_data[ANG_W-1:0];
                CFG_ANGLE_MAX:    r_angle_max    <= i_cfg_data[ANG_W-1:0];
                CFG_ANGLE_CENTER: r_angle_center <= i_cfg_data[ANG_W-1:0];
                CFG_TWIST_THR:    r_twist_thr    <= i_cfg_data[ANG_W-1:0];
                CFG_STICK_DZ:     r_stick_dz     <= i_cfg_data[ANG_W-1:0];
                CFG_DEADBAND:     r_deadband     <= i_cfg_data[ANG_W-1:0];
                CFG_SLEW_STEP:    r_slew_step    <= i_cfg_data[ANG_W-1:0];
                CFG_UPD_INTERVAL: r_upd_interval <= i_cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= RST_ANGLE_CENTER;
            r_lat_l <= 1'b0;
            r_lat_r <= 1'b0;
            r_ms    <= '0;
        end else begin
            if (i_cmd.accept) begin
                case (kind)
                    K_TICK: begin
                        if (r_ms != '1) begin
                            r_ms <= r_ms + 1'b1;
                        end
                    end
                    K_CENTER: begin
                        r_lat_l <= 1'b0;
                        r_lat_r <= 1'b0;
                    end
                    K_SNAP_R: begin
                        r_lat_r <= 1'b1;
                        r_lat_l <= 1'b0;
                    end
                    K_SNAP_L: begin
                        r_lat_l <= 1'b1;
                        r_lat_r <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.slew && !skip) begin
                r_ms <= '0;
            end
            if (i_cmd.clamp) begin
                r_cur <= clamped;
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mdz      <= mdz;
            r_span_mag <= span_mag;
            r_qneg     <= st_neg ^ span[OPD_W-1];
            case (kind)
                K_CENTER: begin
                    r_target <= TGT_W'({1'b0, r_angle_center});
                    r_source <= SRC_CENTER;
                end
                K_SNAP_R: begin
                    r_target <= TGT_W'({1'b0, r_angle_max});
                    r_source <= SRC_RIGHT;
                end
                K_SNAP_L: begin
                    r_target <= TGT_W'({1'b0, r_angle_min});
                    r_source <= SRC_LEFT;
                end
                default: begin
                    r_source <= SRC_PROP;
                end
            endcase
        end
        if (i_cmd.mul_off || i_cmd.mul_duty) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.tgt) begin
            r_target <= r_qneg ? (ctr_ext - quo_ext) : (ctr_ext + quo_ext);
        end
        if (i_cmd.diff) begin
            r_diff <= r_target - cur_ext;
        end
        if (i_cmd.slew && big) begin
            r_target <= r_diff[TGT_W-1] ? (cur_ext - slew_ext) : (cur_ext + slew_ext);
        end
        if (i_cmd.clamp) begin
            r_angle <= clamped;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_angle  <= r_angle;
            r_out_duty   <= duty_sat;
            r_out_source <= r_source;
        end
    end

    assign o_stat.kind     = kind;
    assign o_stat.div_busy = div_busy;
    assign o_stat.skip     = skip;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_angle     = r_out_angle;
    assign o_duty_ns   = r_out_duty;
    assign o_source    = r_out_source;

endmodule

/* hw/rtl/jss_ctrl.sv */
// sequencer that steps the datapath through one sample
module jss_ctrl import jss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_stat.kind)
                        K_CENTER, K_SNAP_R, K_SNAP_L: n_state = S_CLAMP;
                        K_PROP:                       n_state = S_MUL_OFF;
                        default:                      n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL_OFF:    n_state = S_DIVLD_OFF;
            S_DIVLD_OFF:  n_state = S_DIV_OFF;
            S_DIV_OFF: begin
                if (!i_stat.div_busy) begin
                    n_state = S_TGT;
                end
            end
            S_TGT:        n_state = S_DIFF;
            S_DIFF:       n_state = S_SLEW;
            S_SLEW:       n_state = i_stat.skip ? S_IDLE : S_CLAMP;
            S_CLAMP:      n_state = S_MUL_DUTY;
            S_MUL_DUTY:   n_state = S_DIVLD_DUTY;
            S_DIVLD_DUTY: n_state = S_DIV_DUTY;
            S_DIV_DUTY: begin
                if (!i_stat.div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_off    = (r_state == S_MUL_OFF);
        o_cmd.divld_off  = (r_state == S_DIVLD_OFF);
        o_cmd.tgt        = (r_state == S_TGT);
        o_cmd.diff       = (r_state == S_DIFF);
        o_cmd.slew       = (r_state == S_SLEW);
        o_cmd.clamp      = (r_state == S_CLAMP);
        o_cmd.mul_duty   = (r_state == S_MUL_DUTY);
        o_cmd.divld_duty = (r_state == S_DIVLD_DUTY);
        o_cmd.emit       = (r_state == S_DONE) && i_stat.out_free;
        o_in_stall       = (r_state != S_IDLE);
    end

endmodule
